### rtl/core/sha1s_pkg.sv
package sha1s_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_beat_t;

	localparam int unsigned NUM_H = 5;
	localparam logic [2:0] LAST_IDX = 3'd4;

	localparam logic [31:0] INIT_H [NUM_H] = '{
		32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
	};

	localparam logic [31:0] K_0 = 32'h5A82_7999;
	localparam logic [31:0] K_1 = 32'h6ED9_EBA1;
	localparam logic [31:0] K_2 = 32'h8F1B_BCDC;
	localparam logic [31:0] K_3 = 32'hCA62_C1D6;

	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [5:0] LAST_POS   = 6'd63;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [7:0] PAD_MARK   = 8'h80;

endpackage

### rtl/core/sha1_stream_hash_top.sv
// SHA-1 over a byte stream. Each input beat may carry one message byte and may
// mark the end of the message; a beat with both takes the byte first. A beat with
// no byte and no end mark changes nothing. Bytes are shifted into a 512-bit block
// register, one per cycle while the input is ready. The beat that completes a
// 64-byte block also starts the compression: one shared round unit runs the 80
// rounds, one round per cycle, then the add state adds the working words into the
// chaining words; the input is held off until the add is done.
// On the end mark the padding (0x80, zeros, 64-bit big-endian bit length) is
// shifted in one byte per cycle through the same block register, up to 72 bytes
// in all, with one or two compressions between them. The digest then
// leaves as five output beats, h0 first, with word_index 0 to 4 and last_word on
// the fifth; the input is not ready until the last of them has been taken, after
// which the chaining words and the byte count are back at their start values.
module sha1_stream_hash_top
	import sha1s_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_beat,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_beat
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} state_t;

	state_t      state_q;
	logic [31:0] chain_q [NUM_H];
	logic [60:0] cnt_q;     // message length in bytes, wraps
	logic [5:0]  fill_q;    // byte position in the current block
	logic [6:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        pad_q;     // message ended, padding under way
	logic        first_q;   // next pad byte is the 0x80 mark
	logic        len_q;     // length bytes being shifted in

	// block register: word j of the window sits at [511-32*j -: 32]
	logic [511:0] blk_q;
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;

	logic        take_byte;
	logic        shift_byte;
	logic        go_round;
	logic        is_len;
	logic [7:0]  pad_byte;
	logic [7:0]  new_byte;
	logic [63:0] len_bits;
	logic [63:0] len_shifted;
	logic [31:0] w0, w2, w8, w13, w_mix, w_new;
	logic [31:0] f_val, k_val, t_sum;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_beat  = '{digest_word: chain_q[0], word_index: idx_q,
		last_word: (idx_q == LAST_IDX)};

	assign take_byte = in_ready && in_valid && in_beat.byte_present;
	assign shift_byte = take_byte || (state_q == ST_PAD);
	assign go_round  = shift_byte && (fill_q == LAST_POS);

	// padding byte: mark first, zeros up to position 56, then the bit length
	assign is_len      = !first_q && (len_q || fill_q == LEN_POS);
	assign len_bits    = {cnt_q, 3'b000};
	assign len_shifted = len_bits << {fill_q[2:0], 3'b000};

	always_comb begin
		if (first_q) begin
			pad_byte = PAD_MARK;
		end else if (is_len) begin
			pad_byte = len_shifted[63:56];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign new_byte = (state_q == ST_PAD) ? pad_byte : in_beat.data_byte;

	// message schedule off fixed taps of the sliding window
	assign w0    = blk_q[511 -: 32];
	assign w2    = blk_q[511 - 64 -: 32];
	assign w8    = blk_q[511 - 256 -: 32];
	assign w13   = blk_q[511 - 416 -: 32];
	assign w_mix = w13 ^ w8 ^ w2 ^ w0;
	assign w_new = {w_mix[30:0], w_mix[31]};

	// shared round unit
	always_comb begin
		if (rnd_q < 7'd20) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = K_0;
		end else if (rnd_q < 7'd40) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_1;
		end else if (rnd_q < 7'd60) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = K_2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_3;
		end
	end

	assign t_sum = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w0;

	// sequencer, chaining words and output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < NUM_H; i++) begin
				chain_q[i] <= INIT_H[i];
			end
			cnt_q   <= '0;
			fill_q  <= '0;
			rnd_q   <= '0;
			idx_q   <= '0;
			pad_q   <= 1'b0;
			first_q <= 1'b0;
			len_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_beat.byte_present) begin
							cnt_q  <= cnt_q + 61'd1;
							fill_q <= fill_q + 6'd1;
						end
						if (in_beat.end_of_message) begin
							pad_q   <= 1'b1;
							first_q <= 1'b1;
						end
						if (go_round) begin
							rnd_q   <= '0;
							state_q <= ST_ROUND;
						end else if (in_beat.end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					fill_q  <= fill_q + 6'd1;
					first_q <= 1'b0;
					len_q   <= is_len;
					if (go_round) begin
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == LAST_ROUND) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q;
					if (!pad_q) begin
						state_q <= ST_IDLE;
					end else if (len_q) begin
						idx_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						// rotate the digest out and the start values in behind it
						for (int i = 0; i < NUM_H - 1; i++) begin
							chain_q[i] <= chain_q[i + 1];
						end
						chain_q[NUM_H - 1] <= INIT_H[idx_q];
						idx_q <= idx_q + 3'd1;
						if (idx_q == LAST_IDX) begin
							cnt_q   <= '0;
							pad_q   <= 1'b0;
							len_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// block window and working words
	always_ff @(posedge clk) begin
		if (shift_byte) begin
			blk_q <= {blk_q[503:0], new_byte};
		end else if (state_q == ST_ROUND) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (go_round) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (state_q == ST_ROUND) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

endmodule

### rtl/core/sha1s_chk.sv
module sha1s_chk
	import sha1s_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_beat_t  in_beat,
	input logic      out_valid,
	input logic      out_ready,
	input out_beat_t out_beat
);

	// a stalled digest beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_beat))
		else $error("digest beat changed while stalled");

	// input and digest never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while digest pending");

	// digest words follow in order without gaps
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_beat.last_word |=>
			out_valid && out_beat.word_index == $past(out_beat.word_index) + 3'd1)
		else $error("digest word out of order");

	// last_word marks the fifth word only
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_beat.last_word == (out_beat.word_index == LAST_IDX))
		else $error("last_word mismatch");

	// an end mark always leads to padding, never straight back to ready
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_beat.end_of_message |=> !in_ready)
		else $error("ready right after end of message");

endmodule

bind sha1_stream_hash_top sha1s_chk u_sha1s_chk (.*);

### tb/tb_sha1_stream_hash_top.sv
module tb_sha1_stream_hash_top;
	import sha1s_pkg::*;

	// worst case per beat is a long sender gap, an end mark with two padding
	// compressions and five digest beats each behind a long stall; this limit
	// is several times that over the run
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned ITEM_TARGET = 270;

	// keeps its own sha-1 state and queues the five digest beats that each
	// end mark should produce
	class digest_scoreboard;
		logic [31:0] chain [NUM_H];
		logic [31:0] blk [16];
		logic [60:0] byte_cnt;
		out_beat_t   expected_words [$];
		int unsigned errors;

		function new();
			foreach (chain[i]) chain[i] = INIT_H[i];
			foreach (blk[i]) blk[i] = '0;
			byte_cnt = '0;
			errors = 0;
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void compress_block();
			logic [31:0] w [16];
			logic [31:0] a, b, c, d, e, f, k, wt, tmp;
			int t;
			w = blk;
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			e = chain[4];
			for (t = 0; t < 80; t++) begin
				if (t < 16) begin
					wt = w[t];
				end else begin
					wt = w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16];
					wt = {wt[30:0], wt[31]};
					w[t % 16] = wt;
				end
				if (t < 20) begin
					f = (b & c) | (~b & d);
					k = K_0;
				end else if (t < 40) begin
					f = b ^ c ^ d;
					k = K_1;
				end else if (t < 60) begin
					f = (b & c) | (b & d) | (c & d);
					k = K_2;
				end else begin
					f = b ^ c ^ d;
					k = K_3;
				end
				tmp = {a[26:0], a[31:27]} + f + e + k + wt;
				e = d;
				d = c;
				c = {b[1:0], b[31:2]};
				b = a;
				a = tmp;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
			chain[4] += e;
		endfunction

		// big-endian byte placement, compression once the block is full
		function void absorb_byte(logic [5:0] pos, logic [7:0] v);
			int sh;
			sh = 8 * (3 - int'(pos[1:0]));
			if (pos[1:0] == 2'd0) begin
				blk[pos[5:2]] = {v, 24'h0};
			end else begin
				blk[pos[5:2]][sh +: 8] = v;
			end
			if (pos == LAST_POS) begin
				compress_block();
			end
		endfunction

		function void close_message();
			logic [5:0]  pos;
			logic [63:0] bit_len;
			out_beat_t   word;
			int          i;
			pos = byte_cnt[5:0];
			absorb_byte(pos, PAD_MARK);
			pos++;
			while (pos != LEN_POS) begin
				absorb_byte(pos, 8'h00);
				pos++;
			end
			bit_len = {byte_cnt, 3'b000};
			for (i = 0; i < 8; i++) begin
				absorb_byte(pos, bit_len[63 - 8 * i -: 8]);
				pos++;
			end
			for (i = 0; i < NUM_H; i++) begin
				word.digest_word = chain[i];
				word.word_index  = 3'(i);
				word.last_word   = (3'(i) == LAST_IDX);
				expected_words = {expected_words, word};
			end
			foreach (chain[j]) chain[j] = INIT_H[j];
			byte_cnt = '0;
		endfunction

		function void note_beat(in_beat_t b);
			if (b.byte_present) begin
				absorb_byte(byte_cnt[5:0], b.data_byte);
				byte_cnt++;
			end
			if (b.end_of_message) begin
				close_message();
			end
		endfunction

		function void check_word(out_beat_t got);
			out_beat_t want;
			if (expected_words.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected digest beat: %h idx %0d last %0b",
						got.digest_word, got.word_index, got.last_word);
				end
				return;
			end
			want = expected_words.pop_front();
			if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
					got.last_word !== want.last_word) begin
				errors++;
				if (errors <= 10) begin
					$display("digest beat mismatch: expected %h idx %0d last %0b, got %h idx %0d last %0b",
						want.digest_word, want.word_index, want.last_word,
						got.digest_word, got.word_index, got.last_word);
				end
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_beat_t  in_beat = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_beat_t out_beat;

	digest_scoreboard sb = new();
	int unsigned      cycle_count = 0;
	int unsigned      items_sent = 0;

	sha1_stream_hash_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_beat   (in_beat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_beat  (out_beat)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog: a hang anywhere ends the run as a failure
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[sha1_stream_hash_top] ERROR");
			$finish;
		end
	end

	// mostly no gap or a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// message lengths: mostly short, some spanning a block, a few around
	// the one-or-two padding block boundary and past a full block
	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return $urandom_range(0, 12);
		if (r < 85) return $urandom_range(13, 40);
		return $urandom_range(50, 70);
	endfunction

	// digest side: ready in runs of random length, stalls between some of them;
	// an occasional long run gives stretches with no back-pressure at all
	initial begin
		int run;
		int gap;
		forever begin
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// digest beats are taken at the edge where valid and ready are both high
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_word(out_beat);
		end
	end

	// present one beat and hold it until taken; valid stays high afterwards
	// so that a following beat can go straight out
	task automatic send_beat(input logic [7:0] d, input logic present, input logic eom);
		in_beat  <= '{data_byte: d, byte_present: present, end_of_message: eom};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_beat(in_beat);
	endtask

	task automatic pause_in(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// hold the sender off until every queued digest beat has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// one message of random bytes; the end mark either rides on the last
	// byte or comes as an end-only beat whose data lines carry junk
	task automatic send_message(input int len, input bit burst);
		bit joined;
		int i;
		joined = (len > 0) && ($urandom_range(0, 1) == 1);
		for (i = 0; i < len; i++) begin
			if (!burst) pause_in(pick_gap());
			if ($urandom_range(0, 19) == 0) begin
				// beat with neither byte nor end, must be ignored
				send_beat(8'($urandom), 1'b0, 1'b0);
			end
			send_beat(8'($urandom), 1'b1, joined && (i == len - 1));
			items_sent++;
		end
		if (!joined) begin
			if (!burst) pause_in(pick_gap());
			send_beat(8'($urandom), 1'b0, 1'b1);
			items_sent++;
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message straight after reset, data lines all ones
		send_beat(8'hFF, 1'b0, 1'b1);
		// idle beat with neither byte nor end
		send_beat(8'hA5, 1'b0, 1'b0);
		// "abc" with the end mark on the last byte
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(8'h62, 1'b1, 1'b0);
		send_beat(8'h63, 1'b1, 1'b1);
		// single zero byte, then an end-only beat
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'h5A, 1'b0, 1'b1);
		// single all-ones byte carrying the end mark
		send_beat(8'hFF, 1'b1, 1'b1);
		// back-to-back empty messages
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'h3C, 1'b0, 1'b1);
		items_sent = 9;

		// sender waits for the whole digest backlog before going on
		drain_results();

		// padding just fits the block, then just spills into a second one, then a full block of data
		send_message(55, 1'b0);
		send_message(56, 1'b1);
		send_message(64, 1'b0);

		while (items_sent < ITEM_TARGET) begin
			send_message(pick_length(), $urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0) drain_results();
		end

		drain_results();
		// settle time for any stray beat after the last digest
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[sha1_stream_hash_top] OK");
		end else begin
			$display("[sha1_stream_hash_top] ERROR");
		end
		$finish;
	end

endmodule
